/* hw/rtl/retry_backoff_controller_top_macros.svh */
// Assertion shorthands for the retry backoff controller.
// All of them sample on clk and are switched off while rst is high.
`ifndef RETRY_BACKOFF_CONTROLLER_TOP_MACROS_SVH
`define RETRY_BACKOFF_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication.
`define RBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbc check failed");

// Next-cycle implication.
`define RBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbc check failed");

`endif

/* hw/rtl/rbc_pkg.sv */
`default_nettype none
package rbc_pkg;

  // event kinds
  localparam logic [1:0] KIND_FAIL    = 2'd0;
  localparam logic [1:0] KIND_POLL    = 2'd1;
  localparam logic [1:0] KIND_CONSUME = 2'd2;
  localparam logic [1:0] KIND_SUCCESS = 2'd3;

  // failure advice
  localparam logic [1:0] ADV_RETRY  = 2'd0;
  localparam logic [1:0] ADV_RENEG  = 2'd1;
  localparam logic [1:0] ADV_MEDIA  = 2'd2;
  localparam logic [1:0] ADV_OTHER  = 2'd3;

  // decisions
  localparam logic [2:0] DEC_NO_RETRY  = 3'd0;
  localparam logic [2:0] DEC_WAIT      = 3'd1;
  localparam logic [2:0] DEC_READY     = 3'd2;
  localparam logic [2:0] DEC_RENEG     = 3'd3;
  localparam logic [2:0] DEC_MEDIA     = 3'd4;
  localparam logic [2:0] DEC_EXHAUSTED = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] CFG_FIRST_DELAY = 2'd1;
  localparam logic [1:0] CFG_DELAY_CAP   = 2'd2;

  // reset values of the configuration registers
  localparam logic [7:0]  RST_RETRY_LIMIT = 8'd3;
  localparam logic [63:0] RST_FIRST_DELAY = 64'd1;
  localparam logic [63:0] RST_DELAY_CAP   = 64'd1024;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  advice;
    logic [63:0] now;
  } rbc_in_t;

  typedef struct packed {
    logic [2:0] decision;
    logic       granted;
  } rbc_out_t;

  // effective configuration handed to the core
  typedef struct packed {
    logic [7:0]  retry_limit;
    logic [63:0] eff_first;
    logic [63:0] eff_cap;
    logic        load;        // reload current delay this cycle
    logic [63:0] load_delay;
  } rbc_cfg_t;

endpackage
`default_nettype wire

/* hw/rtl/rbc_cfg.sv */
`default_nettype none
module rbc_cfg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [63:0]          cfg_data,
  input  wire logic [7:0]           retries_done,
  output rbc_pkg::rbc_cfg_t         cfg
);
  import rbc_pkg::*;

  logic [7:0]  retry_limit;
  logic [63:0] first_delay;
  logic [63:0] delay_cap;
  logic        recalc;
  logic        wr;

  logic [63:0] eff_first;
  logic [63:0] eff_cap;
  logic [63:0] shifted;
  logic        ovf;
  logic [63:0] lost_mask;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RST_RETRY_LIMIT;
      first_delay <= RST_FIRST_DELAY;
      delay_cap   <= RST_DELAY_CAP;
      recalc      <= 1'b0;
    end else begin
      recalc <= wr && (cfg_index == CFG_FIRST_DELAY || cfg_index == CFG_DELAY_CAP);
      if (wr) begin
        case (cfg_index)
          CFG_RETRY_LIMIT: retry_limit <= cfg_data[7:0];
          CFG_FIRST_DELAY: first_delay <= cfg_data;
          CFG_DELAY_CAP:   delay_cap   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign eff_first = (first_delay == 64'd0) ? 64'd1 : first_delay;
  assign eff_cap   = (delay_cap < eff_first) ? eff_first : delay_cap;

  // delay after n doublings is min(cap, first << n), with overflow going to cap
  assign lost_mask = ~({64{1'b1}} >> retries_done[5:0]);
  assign shifted   = eff_first << retries_done[5:0];
  assign ovf       = (retries_done[7:6] != 2'd0) || ((eff_first & lost_mask) != 64'd0);

  always_comb begin
    cfg.retry_limit = retry_limit;
    cfg.eff_first   = eff_first;
    cfg.eff_cap     = eff_cap;
    cfg.load        = recalc;
    cfg.load_delay  = (ovf || shifted > eff_cap) ? eff_cap : shifted;
  end

endmodule
`default_nettype wire

/* hw/rtl/rbc_core.sv */
`default_nettype none
module rbc_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire rbc_pkg::rbc_in_t     ev,
  input  wire rbc_pkg::rbc_cfg_t    cfg,
  output rbc_pkg::rbc_out_t         res,
  output logic [7:0]                retries_done
);
  import rbc_pkg::*;

  logic [63:0] current_delay;
  logic        waiting;
  logic [63:0] deadline;

  logic [7:0]  retries_done_next;
  logic [63:0] current_delay_next;
  logic        waiting_next;
  logic [63:0] deadline_next;

  logic [64:0] sum;
  logic [63:0] dbl_delay;
  logic [2:0]  poll_dec;

  assign sum = {1'b0, ev.now} + {1'b0, current_delay};

  // doubling capped at the effective cap
  always_comb begin
    dbl_delay = current_delay;
    if (current_delay < cfg.eff_cap) begin
      dbl_delay = (current_delay > cfg.eff_cap - current_delay) ? cfg.eff_cap
                                                                : {current_delay[62:0], 1'b0};
    end
    if (dbl_delay > cfg.eff_cap) begin
      dbl_delay = cfg.eff_cap;
    end
  end

  assign poll_dec = !waiting ? DEC_NO_RETRY : (ev.now < deadline) ? DEC_WAIT : DEC_READY;

  always_comb begin
    retries_done_next  = retries_done;
    current_delay_next = current_delay;
    waiting_next       = waiting;
    deadline_next      = deadline;
    res.decision       = DEC_NO_RETRY;
    res.granted        = 1'b0;
    case (ev.kind)
      KIND_FAIL: begin
        waiting_next  = 1'b0;
        deadline_next = 64'd0;
        case (ev.advice)
          ADV_RENEG: res.decision = DEC_RENEG;
          ADV_MEDIA: res.decision = DEC_MEDIA;
          ADV_OTHER: res.decision = DEC_NO_RETRY;
          default: begin
            if (retries_done >= cfg.retry_limit) begin
              res.decision = DEC_EXHAUSTED;
            end else begin
              deadline_next      = sum[64] ? {64{1'b1}} : sum[63:0];
              waiting_next       = 1'b1;
              retries_done_next  = retries_done + 8'd1;
              current_delay_next = dbl_delay;
              res.decision       = DEC_WAIT;
            end
          end
        endcase
      end
      KIND_POLL: res.decision = poll_dec;
      KIND_CONSUME: begin
        res.decision = poll_dec;
        if (poll_dec == DEC_READY) begin
          waiting_next  = 1'b0;
          deadline_next = 64'd0;
          res.granted   = 1'b1;
        end
      end
      default: begin
        retries_done_next  = 8'd0;
        waiting_next       = 1'b0;
        deadline_next      = 64'd0;
        current_delay_next = cfg.eff_first;
        res.decision       = DEC_NO_RETRY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retries_done  <= 8'd0;
      current_delay <= 64'd1;
      waiting       <= 1'b0;
      deadline      <= 64'd0;
    end else if (cfg.load) begin
      current_delay <= cfg.load_delay;
    end else if (fire) begin
      retries_done  <= retries_done_next;
      current_delay <= current_delay_next;
      waiting       <= waiting_next;
      deadline      <= deadline_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/retry_backoff_controller_top.sv */
// An accepted beat passes through the input register and the result register; each event
// settles in one pass through the decision logic. Throughput: one beat per cycle unless
// out_stall or a delay rebuild holds the input. After a write to first_delay or delay_cap
// the input stalls while the delay is rebuilt from the new values (shift, mask, compare).
// Reset (rst, synchronous, active high) clears both pipeline stages and the retry state and
// restores retry_limit 3, first_delay 1, delay_cap 1024.
`default_nettype none
module retry_backoff_controller_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input events
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire rbc_pkg::rbc_in_t     in_data,
  // decisions
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output rbc_pkg::rbc_out_t         out_data,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [63:0]          cfg_data
);
  import rbc_pkg::*;

  // input register
  logic       in_q_valid;
  rbc_in_t    in_q;
  logic       in_q_valid_next;

  logic       accept;
  logic       advance;     // input beat moves through the core into the result register
  rbc_cfg_t   cfg;
  rbc_out_t   res;
  logic [7:0] retries_done;

  // The result register frees a slot when empty or when its beat is being taken, so the
  // core can run every cycle outside a delay rebuild, even while its beat is being taken.
  // A beat sitting in the input register waits out the delay rebuild, which owns the
  // core state for that cycle.
  assign advance  = in_q_valid && !cfg.load && (!out_valid || !out_stall);
  // Hold off new beats during a delay rebuild (it owns the delay register) or a stuck input beat.
  assign in_stall = cfg.load || (in_q_valid && !advance);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_q_valid_next = in_q_valid;
    if (accept) begin
      in_q_valid_next = 1'b1;
    end else if (advance) begin
      in_q_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else begin
      in_q_valid <= in_q_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= in_data;
    end
  end

  // configuration registers, effective first delay and cap, delay rebuild
  rbc_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .retries_done (retries_done),
    .cfg          (cfg)
  );

  // retry state and decision logic; state moves on a passing beat, the delay also on a rebuild
  rbc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (advance),
    .ev           (in_q),
    .cfg          (cfg),
    .res          (res),
    .retries_done (retries_done)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rbc_checker.sv */
`default_nettype none
`include "retry_backoff_controller_top_macros.svh"
module rbc_checker (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire rbc_pkg::rbc_out_t    out_data
);
  import rbc_pkg::*;

  `RBC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `RBC_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  `RBC_ASSERT_IMP(a_dec_range, out_valid, out_data.decision <= DEC_EXHAUSTED)
  `RBC_ASSERT_IMP(a_grant_ready, out_valid && out_data.granted, out_data.decision == DEC_READY)

endmodule

bind retry_backoff_controller_top rbc_checker u_rbc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
